// ===== sv/sla_pkg.sv =====
// Shared types and constants for the serial line assembler.
// No dependencies; used by sla_obuf and serial_line_assembler_unit.
`default_nettype none

package sla_pkg;

	localparam int unsigned BUF_DEPTH_DEF  = 32;
	localparam int unsigned BYTE_W         = 8;
	localparam logic [7:0]  LINE_TERM_BYTE = 8'h0a;
	localparam logic [7:0]  LINE_END_RESET = 8'd10;

	localparam logic OP_RX    = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_RD,
		ST_LOAD,
		ST_TERM
	} sla_state_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       last;
	} sla_obuf_ld_t;

endpackage

`default_nettype wire

// ===== sv/sla_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sla_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/sla_obuf.sv =====
// Output beat register of the serial line assembler.
// Depends on sla_pkg for the load struct.
`default_nettype none

module sla_obuf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sla_pkg::sla_obuf_ld_t ld,
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [7:0]            m_tdata,
	output      logic                  m_tlast
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			data_q <= ld.data;
			last_q <= ld.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

// ===== sv/serial_line_assembler_unit.sv =====
// Serial line assembler: UART byte ring buffer feeding a line store.
// Depends on sla_pkg, sla_ram and sla_obuf.
//
// Use: the input stream carries one beat per item. s_tuser is the op
// (0 = received byte in s_tdata, 1 = drain one ring byte). A received byte
// is taken while idle; a drain reads the ring memory, then writes the byte
// to the line store unless it is the line-end byte or the store is full.
// A drain that pops the line-end byte starts a burst on the output stream:
// each stored byte is read from the line memory, then loaded into the
// output register, and a final 0x0a beat with m_tlast high ends it. s_tready
// is low while a drain or burst is in progress.
// The output beat sits in its own register, so the last beat of a line may
// wait for m_tready while new items are already accepted. A stalled
// receiver holds the burst one beat at a time; nothing is dropped.
// cfg_we writes cfg_wdata into the line-end byte register; write only idle.
// Reset: ring empty, overflow clear, line store empty, line-end byte 10.
// Memory contents are not cleared and are only read after being written.
`default_nettype none

module serial_line_assembler_unit #(
	parameter int unsigned BUF_DEPTH = sla_pkg::BUF_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output      logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	input  wire logic       s_tuser,   // [0] op
	output      logic       m_tvalid,
	input  wire logic       m_tready,
	output      logic [7:0] m_tdata,   // [7:0] line_byte
	output      logic       m_tlast,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);

	sla_pkg::sla_state_t state_q, state_d;

	logic [IDX_W-1:0] wr_q, rd_q, cnt_q, k_q;
	logic             ovf_q;
	logic [7:0]       lec_q;

	logic [IDX_W-1:0] wr_nxt, rd_nxt;
	logic             full, empty, in_acc, is_rx, is_drain;
	logic             ring_push, ovf_set, drain_go, is_end, line_wr, obuf_free;
	logic [7:0]       ring_rdata, line_rdata;
	sla_pkg::sla_obuf_ld_t obuf_ld;

	assign wr_nxt = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
	assign rd_nxt = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
	assign full   = (wr_nxt == rd_q);
	assign empty  = (wr_q == rd_q);
	assign is_end = (ring_rdata == lec_q);

	// Output and control decode
	always_comb begin
		s_tready  = (state_q == sla_pkg::ST_IDLE);
		in_acc    = s_tvalid && s_tready;
		is_rx     = in_acc && (s_tuser == sla_pkg::OP_RX);
		is_drain  = in_acc && (s_tuser == sla_pkg::OP_DRAIN);
		ring_push = is_rx && !full && (!ovf_q || (s_tdata == lec_q));
		ovf_set   = is_rx && !ovf_q && full;
		drain_go  = is_drain && !empty;
		line_wr   = (state_q == sla_pkg::ST_POP) && !is_end && (cnt_q != LAST_IDX);
		obuf_free = !m_tvalid || m_tready;
		obuf_ld   = '{load: 1'b0, data: line_rdata, last: 1'b0};
		unique case (state_q)
			sla_pkg::ST_LOAD: begin
				obuf_ld.load = 1'b1;
			end
			sla_pkg::ST_TERM: begin
				obuf_ld = '{load: obuf_free, data: sla_pkg::LINE_TERM_BYTE, last: 1'b1};
			end
			default: begin
				obuf_ld.load = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sla_pkg::ST_IDLE: begin
				if (drain_go) state_d = sla_pkg::ST_POP;
			end
			sla_pkg::ST_POP: begin
				if (!is_end) begin
					state_d = sla_pkg::ST_IDLE;
				end else if (cnt_q == '0) begin
					state_d = sla_pkg::ST_TERM;
				end else begin
					state_d = sla_pkg::ST_RD;
				end
			end
			sla_pkg::ST_RD: begin
				if (obuf_free) state_d = sla_pkg::ST_LOAD;
			end
			sla_pkg::ST_LOAD: begin
				state_d = (k_q == cnt_q - 1'b1) ? sla_pkg::ST_TERM : sla_pkg::ST_RD;
			end
			sla_pkg::ST_TERM: begin
				if (obuf_free) state_d = sla_pkg::ST_IDLE;
			end
			default: begin
				state_d = sla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sla_pkg::ST_IDLE;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			ovf_q   <= 1'b0;
			lec_q   <= sla_pkg::LINE_END_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) lec_q <= cfg_wdata;
			if (ring_push) wr_q <= wr_nxt;
			if (drain_go) rd_q <= rd_nxt;
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end else if (ring_push) begin
				ovf_q <= 1'b0;
			end
			if (state_q == sla_pkg::ST_POP) begin
				k_q <= '0;
			end else if (state_q == sla_pkg::ST_LOAD) begin
				k_q <= k_q + 1'b1;
			end
			if (line_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == sla_pkg::ST_TERM && obuf_free) begin
				cnt_q <= '0;
			end
		end
	end

	sla_ram #(
		.WIDTH(sla_pkg::BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_push),
		.waddr(wr_q),
		.wdata(s_tdata),
		.raddr(rd_q),
		.rdata(ring_rdata)
	);

	sla_ram #(
		.WIDTH(sla_pkg::BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (line_wr),
		.waddr(cnt_q),
		.wdata(ring_rdata),
		.raddr(k_q),
		.rdata(line_rdata)
	);

	sla_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (obuf_ld),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q <= LAST_IDX) && (rd_q <= LAST_IDX) && (cnt_q <= LAST_IDX))
		else $error("ring or line index out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sla_pkg::ST_LOAD) |-> !m_tvalid)
		else $error("output register busy when loading a line byte");

	a_ovf_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(full))
		else $error("overflow set with room in the ring");

	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sla_pkg::ST_LOAD) |-> (k_q < cnt_q))
		else $error("line read beyond stored bytes");

endmodule

`default_nettype wire

// ===== tb/tb_serial_line_assembler_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for serial_line_assembler_unit: random UART lines, overflow and drains
// are predicted by a scoreboard class and every output beat is compared in order.
// Depends on sla_pkg and serial_line_assembler_unit.

module tb_serial_line_assembler_unit;

	localparam int unsigned RING_SLOTS = sla_pkg::BUF_DEPTH_DEF;
	localparam int          SETTLE     = 2 * RING_SLOTS + 16;
	localparam int          LIMIT      = 400000;
	localparam int          PHASE_ITEMS = 8;
	localparam int          HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} line_beat_t;

	class line_scoreboard;
		logic [7:0]  fifo_mem [RING_SLOTS];
		int unsigned wptr;
		int unsigned rptr;
		bit          drop_mode;
		logic [7:0]  partial [RING_SLOTS];
		int unsigned partial_len;
		logic [7:0]  term_char;
		line_beat_t  expected_q [$];
		int          errors;

		function new();
			wptr = 0;
			rptr = 0;
			drop_mode = 1'b0;
			partial_len = 0;
			term_char = sla_pkg::LINE_END_RESET;
			errors = 0;
		endfunction

		function bit ring_full();
			return ((wptr + 1) % RING_SLOTS) == rptr;
		endfunction

		function void ring_push(logic [7:0] b);
			fifo_mem[wptr] = b;
			wptr = (wptr + 1) % RING_SLOTS;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_beat(logic op, logic [7:0] b);
			logic [7:0] c;
			if (op == sla_pkg::OP_RX) begin
				if (!drop_mode) begin
					if (ring_full())
						drop_mode = 1'b1;
					else
						ring_push(b);
				end else if (b == term_char && !ring_full()) begin
					ring_push(b);
					drop_mode = 1'b0;
				end
				return;
			end
			if (rptr == wptr)
				return;
			c = fifo_mem[rptr];
			rptr = (rptr + 1) % RING_SLOTS;
			if (c != term_char) begin
				// drop bytes past the line store capacity
				if (partial_len < RING_SLOTS - 1) begin
					partial[partial_len] = c;
					partial_len++;
				end
				return;
			end
			for (int k = 0; k < partial_len; k++)
				expected_q.push_back('{data: partial[k], last: 1'b0});
			expected_q.push_back('{data: sla_pkg::LINE_TERM_BYTE, last: 1'b1});
			partial_len = 0;
		endfunction

		function void check_beat(logic [7:0] d, logic l);
			line_beat_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual data=%02h last=%0b",
					$time, d, l);
				return;
			end
			want = expected_q.pop_front();
			if (d !== want.data) begin
				errors++;
				$display("%0t: line_byte mismatch, expected %02h actual %02h",
					$time, want.data, d);
			end
			if (l !== want.last) begin
				errors++;
				$display("%0t: last_of_line mismatch, expected %0b actual %0b",
					$time, want.last, l);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	line_scoreboard sb = new();
	int items_sent;
	bit idle_on;
	bit hold_req;
	int hold_left;
	int rx_gap;

	serial_line_assembler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_beat(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tlast);
	end

	// receiver: random stall per beat, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		rx_gap = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (m_tready) begin
				if (m_tvalid) begin
					rx_gap = idle_on ? $urandom_range(0, 10) : 0;
					if (rx_gap > 0)
						m_tready <= 1'b0;
				end
			end else if (rx_gap > 0) begin
				rx_gap--;
				if (rx_gap == 0)
					m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input logic op, input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain(input int n);
		repeat (n) send_beat(sla_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == sb.term_char);
		return b;
	endfunction

	// n body bytes, then the terminator; drain_pct sets how often a drain follows a byte
	task automatic send_line(input int n, input int drain_pct);
		int drained;
		drained = 0;
		for (int i = 0; i < n; i++) begin
			send_beat(sla_pkg::OP_RX, plain_byte());
			if ($urandom_range(1, 100) <= drain_pct) begin
				drain(1);
				drained++;
			end
		end
		send_beat(sla_pkg::OP_RX, sb.term_char);
		drain(n + 1 - drained + $urandom_range(0, 2));
	endtask

	task automatic overflow_line();
		repeat (RING_SLOTS + 1) send_beat(sla_pkg::OP_RX, plain_byte());
		send_beat(sla_pkg::OP_RX, sb.term_char);
		drain(3);
		send_beat(sla_pkg::OP_RX, plain_byte());
		send_beat(sla_pkg::OP_RX, sb.term_char);
		drain(RING_SLOTS);
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		idle_on = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			send_line($urandom_range(0, 12), $urandom_range(0, 60));
		end else if (pick < 63) begin
			send_line($urandom_range(RING_SLOTS - 3, RING_SLOTS + 8), 100);
		end else if (pick < 70) begin
			overflow_line();
		end else if (pick < 88) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					send_beat(1'($urandom_range(0, 1)), sb.term_char);
				else
					send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end else begin
			send_beat(sla_pkg::OP_RX, sb.term_char);
			drain(1);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_line_end(input logic [7:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.term_char = v;
	endtask

	initial begin
		logic [7:0] settings [5];
		int phase_start;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = sla_pkg::OP_RX;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		items_sent = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty drain, empty line, field extremes, reset terminator
		idle_on = 1'b0;
		drain(1);
		send_beat(sla_pkg::OP_RX, sla_pkg::LINE_END_RESET);
		drain(1);
		send_beat(sla_pkg::OP_RX, 8'h00);
		send_beat(sla_pkg::OP_RX, 8'hff);
		send_beat(sla_pkg::OP_RX, 8'h55);
		send_beat(sla_pkg::OP_RX, 8'haa);
		send_beat(sla_pkg::OP_RX, sla_pkg::LINE_END_RESET);
		drain(6);
		idle_on = 1'b1;
		send_line(3, 50);

		settings[0] = 8'h00;
		settings[1] = 8'hff;
		settings[2] = sla_pkg::LINE_TERM_BYTE;
		settings[3] = 8'($urandom_range(0, 255));
		settings[4] = 8'($urandom_range(0, 255));
		for (int ph = 0; ph < 5; ph++) begin
			write_line_end(settings[ph]);
			phase_start = items_sent;
			if (ph == 0)
				overflow_line();
			if (ph == 1)
				send_line(RING_SLOTS + 4, 100);
			if (ph == 2) begin
				// hold the output while lines keep arriving
				idle_on = 1'b0;
				hold_req = 1'b1;
				repeat (2) send_line(8, 50);
			end
			while (items_sent - phase_start < PHASE_ITEMS)
				random_sequence();
		end

		settle();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/sla_pkg.sv
sv/sla_ram.sv
sv/sla_obuf.sv
sv/serial_line_assembler_unit.sv
tb/tb_serial_line_assembler_unit.sv
